FILE: rtl/core/r2n_pkg.sv
package r2n_pkg;

  localparam int MAX_WIDTH      = 4096;
  localparam int MAX_HEIGHT     = 4096;
  localparam int COEF_FRAC_BITS = 16;

  localparam int DIM_W  = 13;
  localparam int CNT_W  = 12;
  localparam int ADDR_W = 25;
  localparam int PIX_W  = 32;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
  localparam logic [DIM_W-1:0] RESET_STRIDE = DIM_W'(640);

  localparam int SUM_W = COEF_FRAC_BITS + 11;
  localparam int Q_W   = SUM_W - 1 - COEF_FRAC_BITS;

  localparam logic signed [SUM_W-1:0] OFS_Y = SUM_W'(16 << COEF_FRAC_BITS);
  localparam logic signed [SUM_W-1:0] OFS_C = SUM_W'(128 << COEF_FRAC_BITS);

  localparam logic signed [SUM_W-1:0] C257 = SUM_W'(((257 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [SUM_W-1:0] C504 = SUM_W'(((504 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [SUM_W-1:0] C098 = SUM_W'(((98 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [SUM_W-1:0] C439 = SUM_W'(((439 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [SUM_W-1:0] C368 = SUM_W'(((368 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [SUM_W-1:0] C071 = SUM_W'(((71 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [SUM_W-1:0] C148 = SUM_W'(((148 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [SUM_W-1:0] C291 = SUM_W'(((291 << COEF_FRAC_BITS) + 500) / 1000);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ROW_STRIDE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_LUMA = 2'd0,
    KIND_CB   = 2'd1,
    KIND_CR   = 2'd2
  } sample_kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0] luma_addr;
    logic [ADDR_W-1:0] chroma_off;
    logic              chroma;
    logic              fend;
  } pix_ctrl_t;

  typedef struct packed {
    logic [7:0]        y;
    logic [7:0]        cb;
    logic [7:0]        cr;
    logic [ADDR_W-1:0] luma_addr;
    logic [ADDR_W-1:0] chroma_addr;
    logic              chroma;
    logic              fend;
  } conv_item_t;

  // floor(s / 2^F) clamped to 0..255
  function automatic logic [7:0] clamp_sample(logic signed [SUM_W-1:0] s);
    logic [Q_W-1:0] q;
    begin
      q = s[SUM_W-2:COEF_FRAC_BITS];
      if (s[SUM_W-1]) begin
        return 8'd0;
      end else if (|q[Q_W-1:8]) begin
        return 8'd255;
      end else begin
        return q[7:0];
      end
    end
  endfunction

endpackage

FILE: rtl/core/r2n_pixel_if.sv
interface r2n_pixel_if;
  logic                     valid;
  logic                     ready;
  logic [r2n_pkg::PIX_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink (input valid, input pixel_word, output ready);
endinterface

FILE: rtl/core/r2n_sample_if.sv
interface r2n_sample_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 sample_byte;
  logic [r2n_pkg::ADDR_W-1:0] byte_address;
  r2n_pkg::sample_kind_t      sample_kind;
  logic                       frame_end;
  logic                       run_last;

  modport source (output valid, output sample_byte, output byte_address,
                  output sample_kind, output frame_end, output run_last, input ready);
  modport sink (input valid, input sample_byte, input byte_address,
                input sample_kind, input frame_end, input run_last, output ready);
endinterface

FILE: rtl/core/r2n_frame_ctrl.sv
module r2n_frame_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [r2n_pkg::DIM_W-1:0]  cfg_data,
  input  logic                       accept,
  output r2n_pkg::pix_ctrl_t         ctrl,
  output logic [r2n_pkg::ADDR_W-1:0] chroma_base
);

  localparam int DIM_W  = r2n_pkg::DIM_W;
  localparam int CNT_W  = r2n_pkg::CNT_W;
  localparam int ADDR_W = r2n_pkg::ADDR_W;

  localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(r2n_pkg::MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(r2n_pkg::MAX_HEIGHT);
  localparam logic [2*DIM_W-1:0] RESET_BASE = (2*DIM_W)'(r2n_pkg::RESET_STRIDE)
                                            * (2*DIM_W)'(r2n_pkg::RESET_HEIGHT);

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [DIM_W-1:0]   row_stride;
  logic [CNT_W-1:0]   column_count;
  logic [CNT_W-1:0]   row_count;
  logic [ADDR_W-1:0]  luma_address;
  logic [ADDR_W-1:0]  chroma_offset;
  logic               running_parity;

  logic [DIM_W-1:0]   eff_w;
  logic [DIM_W-1:0]   eff_h;
  logic [DIM_W-1:0]   eff_s;
  logic [2*DIM_W-1:0] base_prod;
  logic               row_end;
  logic               fend;
  logic               even_row;
  logic               chroma;
  logic [ADDR_W-1:0]  pad;
  logic [ADDR_W-1:0]  luma_step;
  logic [ADDR_W-1:0]  chroma_step;
  logic               restart;

  function automatic logic [DIM_W-1:0] sat_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] mx);
    begin
      if (v == '0) begin
        return DIM_W'(1);
      end else if (v > mx) begin
        return mx;
      end else begin
        return v;
      end
    end
  endfunction

  always_comb begin
    eff_w     = sat_dim(frame_width, MAX_W_D);
    eff_h     = sat_dim(frame_height, MAX_H_D);
    eff_s     = sat_dim(row_stride, MAX_W_D);
    base_prod = (2*DIM_W)'(eff_s) * (2*DIM_W)'(eff_h);
  end

  always_comb begin
    row_end     = ({1'b0, column_count} + DIM_W'(1)) >= eff_w;
    fend        = row_end && (({1'b0, row_count} + DIM_W'(1)) >= eff_h);
    even_row    = !row_count[0];
    chroma      = even_row && running_parity;
    pad         = {{(ADDR_W-DIM_W){1'b0}}, DIM_W'(eff_s - eff_w)};
    luma_step   = luma_address + ADDR_W'(1);
    chroma_step = chroma ? chroma_offset + ADDR_W'(2) : chroma_offset;
    restart     = cfg_we && (cfg_index == r2n_pkg::REG_FRAME_WIDTH
                          || cfg_index == r2n_pkg::REG_FRAME_HEIGHT
                          || cfg_index == r2n_pkg::REG_ROW_STRIDE);
  end

  always_comb begin
    ctrl.luma_addr  = luma_address;
    ctrl.chroma_off = chroma_offset;
    ctrl.chroma     = chroma;
    ctrl.fend       = fend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_base <= RESET_BASE[ADDR_W-1:0];
    end else begin
      chroma_base <= base_prod[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= r2n_pkg::RESET_WIDTH;
      frame_height   <= r2n_pkg::RESET_HEIGHT;
      row_stride     <= r2n_pkg::RESET_STRIDE;
      column_count   <= '0;
      row_count      <= '0;
      luma_address   <= '0;
      chroma_offset  <= '0;
      running_parity <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        r2n_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        r2n_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        r2n_pkg::REG_ROW_STRIDE:   row_stride   <= cfg_data;
        default: ;
      endcase
      if (restart) begin
        column_count   <= '0;
        row_count      <= '0;
        luma_address   <= '0;
        chroma_offset  <= '0;
        running_parity <= 1'b0;
      end
    end else if (accept) begin
      if (fend) begin
        column_count   <= '0;
        row_count      <= '0;
        luma_address   <= '0;
        chroma_offset  <= '0;
        running_parity <= 1'b0;
      end else begin
        running_parity <= !running_parity;
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + CNT_W'(1);
          if (eff_s > eff_w) begin
            luma_address  <= luma_step + pad;
            chroma_offset <= even_row ? chroma_step + pad : chroma_step;
          end else begin
            luma_address  <= luma_step;
            chroma_offset <= chroma_step;
          end
        end else begin
          column_count  <= column_count + CNT_W'(1);
          luma_address  <= luma_step;
          chroma_offset <= chroma_step;
        end
      end
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column_count} < eff_w)
    else $error("column count past row width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    {1'b0, row_count} < eff_h)
    else $error("row count past frame height");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && fend && !cfg_we |=> luma_address == '0 && chroma_offset == '0
                                  && !running_parity)
    else $error("state not reloaded after last pixel");

endmodule

FILE: rtl/core/r2n_csc.sv
module r2n_csc (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [r2n_pkg::PIX_W-1:0]  pixel_word,
  input  r2n_pkg::pix_ctrl_t         ctrl,
  input  logic [r2n_pkg::ADDR_W-1:0] chroma_base,
  output logic                       out_valid,
  input  logic                       out_ready,
  output r2n_pkg::conv_item_t        out_item
);

  localparam int SUM_W = r2n_pkg::SUM_W;

  logic                      s1_valid;
  logic [7:0]                s1_r;
  logic [7:0]                s1_g;
  logic [7:0]                s1_b;
  r2n_pkg::pix_ctrl_t        s1_ctrl;
  logic                      s1_ready;
  logic                      s2_ready;

  logic signed [SUM_W-1:0]   sr;
  logic signed [SUM_W-1:0]   sg;
  logic signed [SUM_W-1:0]   sb;
  logic signed [SUM_W-1:0]   y_sum;
  logic signed [SUM_W-1:0]   cb_sum;
  logic signed [SUM_W-1:0]   cr_sum;
  r2n_pkg::conv_item_t       item_next;

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_comb begin
    sr     = $signed({{(SUM_W-8){1'b0}}, s1_r});
    sg     = $signed({{(SUM_W-8){1'b0}}, s1_g});
    sb     = $signed({{(SUM_W-8){1'b0}}, s1_b});
    y_sum  = r2n_pkg::OFS_Y + sr * r2n_pkg::C257 + sg * r2n_pkg::C504 + sb * r2n_pkg::C098;
    cb_sum = r2n_pkg::OFS_C - sr * r2n_pkg::C148 - sg * r2n_pkg::C291 + sb * r2n_pkg::C439;
    cr_sum = r2n_pkg::OFS_C + sr * r2n_pkg::C439 - sg * r2n_pkg::C368 - sb * r2n_pkg::C071;

    item_next.y           = r2n_pkg::clamp_sample(y_sum);
    item_next.cb          = r2n_pkg::clamp_sample(cb_sum);
    item_next.cr          = r2n_pkg::clamp_sample(cr_sum);
    item_next.luma_addr   = s1_ctrl.luma_addr;
    item_next.chroma_addr = chroma_base + s1_ctrl.chroma_off;
    item_next.chroma      = s1_ctrl.chroma;
    item_next.fend        = s1_ctrl.fend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_r    <= pixel_word[23:16];
      s1_g    <= pixel_word[15:8];
      s1_b    <= pixel_word[7:0];
      s1_ctrl <= ctrl;
    end
    if (s1_valid && s2_ready) begin
      out_item <= item_next;
    end
  end

endmodule

FILE: rtl/core/r2n_sample_seq.sv
module r2n_sample_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  r2n_pkg::conv_item_t item,
  r2n_sample_if.source        samples
);

  localparam int ADDR_W = r2n_pkg::ADDR_W;

  logic                  busy;
  r2n_pkg::conv_item_t   hold;
  r2n_pkg::sample_kind_t kind;
  r2n_pkg::sample_kind_t kind_next;
  logic                  last;

  always_comb begin
    last       = (kind == r2n_pkg::KIND_CR) || (kind == r2n_pkg::KIND_LUMA && !hold.chroma);
    item_ready = !busy || (samples.ready && last);
  end

  always_comb begin
    unique case (kind)
      r2n_pkg::KIND_LUMA: kind_next = r2n_pkg::KIND_CB;
      r2n_pkg::KIND_CB:   kind_next = r2n_pkg::KIND_CR;
      default:            kind_next = r2n_pkg::KIND_LUMA;
    endcase
  end

  always_comb begin
    samples.valid       = busy;
    samples.sample_kind = kind;
    samples.frame_end   = hold.fend;
    samples.run_last    = last;
    unique case (kind)
      r2n_pkg::KIND_CB: begin
        samples.sample_byte  = hold.cb;
        samples.byte_address = hold.chroma_addr;
      end
      r2n_pkg::KIND_CR: begin
        samples.sample_byte  = hold.cr;
        samples.byte_address = hold.chroma_addr + ADDR_W'(1);
      end
      default: begin
        samples.sample_byte  = hold.y;
        samples.byte_address = hold.luma_addr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      kind <= r2n_pkg::KIND_LUMA;
    end else if (item_ready) begin
      busy <= item_valid;
      kind <= r2n_pkg::KIND_LUMA;
    end else if (samples.ready) begin
      kind <= kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      hold <= item;
    end
  end

  a_chroma_phase: assert property (@(posedge clk) disable iff (rst)
    busy && kind != r2n_pkg::KIND_LUMA |-> hold.chroma)
    else $error("chroma phase on a luma-only item");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready && !samples.run_last |=> samples.valid
      && $stable(hold.luma_addr) && kind == $past(kind_next))
    else $error("item run broken before its last sample");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    busy && !samples.ready |=> busy && kind == $past(kind))
    else $error("phase moved during stall");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy)
    else $error("output busy after reset");

endmodule

FILE: rtl/core/rgb_to_nv12_converter_top.sv
// RGB to NV12 converter.
// pixels: one packed pixel per item (red 23:16, green 15:8, blue 7:0), raster
// order. samples: one byte per item with its frame buffer address, kind
// (luma, Cb, Cr), frame_end and run_last marking the last byte of a pixel.
// Config port: cfg_we/cfg_index/cfg_data write frame_width, frame_height,
// row_stride; any valid write restarts the frame. Write only while idle.
// Path: the luma byte of an accepted pixel passes the input register, the
// conversion register and the output hold register before it is presented.
// Throughput: a pixel is accepted every cycle while the output keeps up;
// the one-byte output port sends one byte per luma-only pixel and three
// per pixel that also carries Cb and Cr, so even rows average two bytes
// per pixel, odd rows one, a frame about 1.5.
// Reset: registers return to 640x480 stride 640, all stages empty, no
// clearing pass. A stalled output holds its byte and back-pressures the
// two pipeline registers, then pixels.ready drops.
module rgb_to_nv12_converter_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [r2n_pkg::DIM_W-1:0] cfg_data,
  r2n_pixel_if.sink                 pixels,
  r2n_sample_if.source              samples
);

  r2n_pkg::pix_ctrl_t         ctrl;
  logic [r2n_pkg::ADDR_W-1:0] chroma_base;
  logic                       pix_ready;
  logic                       conv_valid;
  logic                       conv_ready;
  r2n_pkg::conv_item_t        conv_item;

  assign pixels.ready = pix_ready;

  r2n_frame_ctrl u_frame_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (pixels.valid && pix_ready),
    .ctrl        (ctrl),
    .chroma_base (chroma_base)
  );

  r2n_csc u_csc (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (pixels.valid),
    .in_ready    (pix_ready),
    .pixel_word  (pixels.pixel_word),
    .ctrl        (ctrl),
    .chroma_base (chroma_base),
    .out_valid   (conv_valid),
    .out_ready   (conv_ready),
    .out_item    (conv_item)
  );

  r2n_sample_seq u_sample_seq (
    .clk        (clk),
    .rst        (rst),
    .item_valid (conv_valid),
    .item_ready (conv_ready),
    .item       (conv_item),
    .samples    (samples)
  );

endmodule
